// ===== src/gcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, constants and the per-stage item record of the greedy
// coin-change pipeline.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int MAX_SLOTS          = 8;
    localparam int SLOT_W             = 3;
    localparam int VAL_W              = 16;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = VAL_W / DIV_BITS_PER_STAGE;
    localparam int DEF_NUM_SLOTS      = 8;

    // Record carried by each pipeline stage alongside its valid bit.
    //   rest   : remainder entering the slot under division
    //   acc    : {partial remainder, dividend/quotient} shift register
    //   counts : coin counts of slots already finished
    //   rems   : remainders after slots already finished
    typedef struct packed {
        logic [VAL_W-1:0]                  rest;
        logic [2*VAL_W-1:0]                acc;
        logic [MAX_SLOTS-1:0][VAL_W-1:0]   counts;
        logic [MAX_SLOTS-1:0][VAL_W-1:0]   rems;
    } gcc_item_t;

endpackage
`default_nettype wire

// ===== src/gcc_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_div_stage
// One register stage of a slot's restoring divider: four quotient bits.
// The first stage of a slot loads the dividend, the last one stores the
// slot's count and remainder.
// ----------------------------------------------------------------------------
module gcc_div_stage #(
    parameter int SLOT  = 0,
    parameter bit FIRST = 1'b0,
    parameter bit LAST  = 1'b0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic [gcc_pkg::VAL_W-1:0] divisor,
    input  wire logic                     in_valid,
    input  wire gcc_pkg::gcc_item_t       in_item,
    output logic                          out_valid,
    output gcc_pkg::gcc_item_t            out_item
);
    import gcc_pkg::*;

    logic      valid_reg;
    gcc_item_t item_reg;
    gcc_item_t item_next;

    always_comb
    begin
        logic [2*VAL_W:0] a;
        a         = '0;
        item_next = in_item;
        if (FIRST)
        begin
            a = {{(VAL_W+1){1'b0}}, in_item.rest};
        end
        else
        begin
            a = {1'b0, in_item.acc};
        end
        // restoring division: shift, compare, subtract
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            a = {a[2*VAL_W-1:0], 1'b0};
            if (a[2*VAL_W:VAL_W] >= {1'b0, divisor})
            begin
                a[2*VAL_W:VAL_W] = a[2*VAL_W:VAL_W] - {1'b0, divisor};
                a[0]             = 1'b1;
            end
        end
        item_next.acc = a[2*VAL_W-1:0];
        if (LAST)
        begin
            // unused slot: no coins, remainder passes unchanged
            if (divisor == '0)
            begin
                item_next.counts[SLOT] = '0;
                item_next.rems[SLOT]   = in_item.rest;
            end
            else
            begin
                item_next.counts[SLOT] = a[VAL_W-1:0];
                item_next.rems[SLOT]   = a[2*VAL_W-1:VAL_W];
                item_next.rest         = a[2*VAL_W-1:VAL_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ===== src/gcc_out_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_out_ser
// Output register: holds one finished item and hands out one result per
// slot. Takes the next item as the final result of the current one leaves.
// ----------------------------------------------------------------------------
module gcc_out_ser #(
    parameter int NUM_SLOTS = gcc_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire gcc_pkg::gcc_item_t         in_item,
    output logic                            advance,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [gcc_pkg::SLOT_W-1:0]      slot,
    output logic [gcc_pkg::VAL_W-1:0]       coin_count,
    output logic [gcc_pkg::VAL_W-1:0]       remainder_left,
    output logic                            last
);
    import gcc_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic                              busy_reg;
    logic [SLOT_W-1:0]                 slot_reg;
    logic [MAX_SLOTS-1:0][VAL_W-1:0]   counts_reg;
    logic [MAX_SLOTS-1:0][VAL_W-1:0]   rems_reg;
    logic                              is_last;
    logic                              take;
    logic                              load;

    assign is_last = (slot_reg == LAST_SLOT);
    assign take    = busy_reg && out_ready;
    // pipeline moves when the last stage is empty, or there is room for its item: empty, or the final result leaves now
    assign advance = !in_valid || !busy_reg || (take && is_last);
    assign load    = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            counts_reg <= in_item.counts;
            rems_reg   <= in_item.rems;
        end
    end

    assign out_valid      = busy_reg;
    assign slot           = slot_reg;
    assign coin_count     = counts_reg[slot_reg];
    assign remainder_left = rems_reg[slot_reg];
    assign last           = is_last;

endmodule
`default_nettype wire

// ===== src/greedy_coin_change.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_coin_change
// Greedy change making over up to eight configured coin values, built as a
// pipeline of restoring dividers followed by an output serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Program coin_value_0..7 through the cfg port (cfg_wr_en, cfg_index,
//   cfg_data) while the block is idle; slot order should be largest first,
//   and a zero value marks a slot as unused (count 0, remainder unchanged).
//   Each amount item on in_valid/in_ready yields NUM_SLOTS result items on
//   out_valid/out_ready, in slot order, with last set on the final one.
//   Every slot takes four divider stages of four quotient bits each; the
//   first stage loads at the accepting edge and the output register loads
//   from the last stage once it has room.
//   Throughput: the single result port limits the sustained rate; the
//   pipeline takes a new amount every cycle until the output register is
//   full, and accepts the next one while results still drain.
//   Reset clears all coin values to zero and empties the pipeline.
//   When the receiver stalls and an item waits in the last stage, the
//   whole pipeline holds; nothing is dropped or repeated. NUM_SLOTS
//   outside 1..8 is clamped into that range.
// ----------------------------------------------------------------------------
module greedy_coin_change #(
    parameter int NUM_SLOTS = gcc_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gcc_pkg::SLOT_W-1:0]  cfg_index,
    input  wire logic [gcc_pkg::VAL_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gcc_pkg::VAL_W-1:0]   amount,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [gcc_pkg::SLOT_W-1:0]       slot,
    output logic [gcc_pkg::VAL_W-1:0]        coin_count,
    output logic [gcc_pkg::VAL_W-1:0]        remainder_left,
    output logic                             last
);
    import gcc_pkg::*;

    // Slots actually walked, clamped into 1..MAX_SLOTS.
    localparam int SLOTS_USED = (NUM_SLOTS < 1) ? 1 :
                                (NUM_SLOTS > MAX_SLOTS) ? MAX_SLOTS : NUM_SLOTS;
    localparam int NUM_STAGES = SLOTS_USED * DIV_STAGES;

    // Coin value registers
    logic [MAX_SLOTS-1:0][VAL_W-1:0] coin_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            coin_value_reg[cfg_index] <= cfg_data;
        end
    end

    // Pipeline: entry 0 is the input side, entry NUM_STAGES the last stage.
    logic      pipe_valid [NUM_STAGES+1];
    gcc_item_t pipe_item  [NUM_STAGES+1];
    logic      advance;

    always_comb
    begin
        pipe_item[0]        = '0;
        pipe_item[0].rest   = amount;
    end
    assign pipe_valid[0] = in_valid;

    // Whole pipeline moves together; hold all stages while the output
    // register cannot take the item at the end.
    assign in_ready = advance;

    for (genvar s = 0; s < SLOTS_USED; s++)
    begin : g_slot
        for (genvar j = 0; j < DIV_STAGES; j++)
        begin : g_step
            gcc_div_stage #(
                .SLOT  (s),
                .FIRST (j == 0),
                .LAST  (j == DIV_STAGES - 1)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (advance),
                .divisor   (coin_value_reg[s]),
                .in_valid  (pipe_valid[s*DIV_STAGES + j]),
                .in_item   (pipe_item[s*DIV_STAGES + j]),
                .out_valid (pipe_valid[s*DIV_STAGES + j + 1]),
                .out_item  (pipe_item[s*DIV_STAGES + j + 1])
            );
        end
    end

    // Output register: one result per slot, drained by the receiver.
    gcc_out_ser #(
        .NUM_SLOTS (SLOTS_USED)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pipe_valid[NUM_STAGES]),
        .in_item        (pipe_item[NUM_STAGES]),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .coin_count     (coin_count),
        .remainder_left (remainder_left),
        .last           (last)
    );

endmodule
`default_nettype wire

// ===== tb/greedy_coin_change_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_coin_change_checker
// Watches the config port and both item channels of greedy_coin_change,
// splits every accepted amount into its expected per-slot results and
// compares each result item against the oldest one still owed.
// ----------------------------------------------------------------------------
module greedy_coin_change_checker #(
    parameter int NUM_SLOTS = gcc_pkg::DEF_NUM_SLOTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gcc_pkg::SLOT_W-1:0]  cfg_index,
    input  wire logic [gcc_pkg::VAL_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [gcc_pkg::VAL_W-1:0]   amount,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [gcc_pkg::SLOT_W-1:0]  slot,
    input  wire logic [gcc_pkg::VAL_W-1:0]   coin_count,
    input  wire logic [gcc_pkg::VAL_W-1:0]   remainder_left,
    input  wire logic                        last,
    output int                               fail_count,
    output int                               owed_results
);
    import gcc_pkg::*;

    localparam int SLOTS_USED = (NUM_SLOTS < 1) ? 1 :
                                (NUM_SLOTS > MAX_SLOTS) ? MAX_SLOTS : NUM_SLOTS;

    typedef struct packed {
        logic [VAL_W-1:0]  amt;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  coins;
        logic [VAL_W-1:0]  rest;
        logic              last;
    } change_entry_t;

    logic [VAL_W-1:0] coin_value_q [MAX_SLOTS];
    change_entry_t    owed_entries [$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    // Walk the slots in index order; a zero value leaves the remainder alone.
    function automatic void split_into_coins(input logic [VAL_W-1:0] amt);
        logic [VAL_W-1:0] rest;
        change_entry_t    e;
        rest = amt;
        for (int k = 0; k < SLOTS_USED; k++)
        begin
            e.amt   = amt;
            e.slot  = SLOT_W'(k);
            e.coins = '0;
            if (coin_value_q[k] != '0)
            begin
                e.coins = rest / coin_value_q[k];
                rest    = rest % coin_value_q[k];
            end
            e.rest = rest;
            e.last = (k == SLOTS_USED - 1);
            owed_entries = {owed_entries, e};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        change_entry_t want;
        if (!rst_n)
        begin
            foreach (coin_value_q[k])
                coin_value_q[k] = '0;
            owed_entries.delete();
            fail_count = 0;
            owed_results <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                split_into_coins(amount);
            if (out_valid && out_ready)
            begin
                if (owed_entries.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result item slot %0d", slot));
                end
                else
                begin
                    want = owed_entries.pop_front();
                    if (slot !== want.slot)
                        report_mismatch($sformatf("amount %0d: slot %0d, want %0d",
                                                  want.amt, slot, want.slot));
                    if (coin_count !== want.coins)
                        report_mismatch($sformatf("amount %0d slot %0d: count %0d, want %0d",
                                                  want.amt, want.slot, coin_count, want.coins));
                    if (remainder_left !== want.rest)
                        report_mismatch($sformatf("amount %0d slot %0d: rest %0d, want %0d",
                                                  want.amt, want.slot, remainder_left,
                                                  want.rest));
                    if (last !== want.last)
                        report_mismatch($sformatf("amount %0d slot %0d: last %b, want %b",
                                                  want.amt, want.slot, last, want.last));
                end
            end
            // cfg_index is three bits wide, so every write lands on a slot.
            if (cfg_wr_en)
                coin_value_q[cfg_index] = cfg_data;
            owed_results <= owed_entries.size();
        end
    end

endmodule

// ===== tb/greedy_coin_change_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_coin_change_tb
// Drives amounts into greedy_coin_change under a series of coin value sets
// (reset zeros, a common coin set, extreme and unordered sets, then random
// sets) with random idling on both channels; the checker predicts and
// compares every result item, and this top gives the verdict.
// ----------------------------------------------------------------------------
module greedy_coin_change_tb;
    import gcc_pkg::*;

    localparam int NUM_SLOTS     = DEF_NUM_SLOTS;
    // Four divider stages per slot plus the output register, then some slack.
    localparam int PIPE_LATENCY  = 4 * NUM_SLOTS + 1;
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 58;
    // Watchdog limit, far above what a correct run needs.
    localparam int CYCLE_LIMIT   = 300_000;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [SLOT_W-1:0]   cfg_index      = '0;
    logic [VAL_W-1:0]    cfg_data       = '0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [VAL_W-1:0]    amount         = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [SLOT_W-1:0]   slot;
    logic [VAL_W-1:0]    coin_count;
    logic [VAL_W-1:0]    remainder_left;
    logic                last;

    int                  fail_count;
    int                  owed_results;
    int                  cycle_count    = 0;
    // While set, neither side idles: one long stretch of back-to-back items.
    logic                steady_flow    = 1'b0;
    // Coin values as last programmed, used to aim amounts at interesting spots.
    logic [VAL_W-1:0]    coin_set [MAX_SLOTS];

    greedy_coin_change #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .coin_count     (coin_count),
        .remainder_left (remainder_left),
        .last           (last)
    );

    greedy_coin_change_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .coin_count     (coin_count),
        .remainder_left (remainder_left),
        .last           (last),
        .fail_count     (fail_count),
        .owed_results   (owed_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random about 30 percent of the time, except in the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 30);
    end

    // Watchdog: give up if the run hangs or results never drain.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one amount item, idling first at random; hold valid and payload
    // until the item is taken. Valid stays high on return so the next item
    // can follow without a gap.
    task automatic send_amount(input logic [VAL_W-1:0] a);
        while (!steady_flow && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        amount   <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed result is out and the pipe is empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all eight coin values from coin_set, one register per cycle,
    // only once the block has gone idle.
    task automatic program_coins();
        drain_results();
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= SLOT_W'(k);
            cfg_data  <= coin_set[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Fill coin_set with a random mix: unused slots, ones, full-scale values
    // and values of every magnitude; mostly sorted largest first, sometimes not.
    task automatic randomize_coins();
        logic [VAL_W-1:0] tmp;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    coin_set[k] = '0;
                2:       coin_set[k] = VAL_W'(1);
                3:       coin_set[k] = '1;
                default: coin_set[k] = VAL_W'($urandom_range(1, 65535) >> $urandom_range(0, 15));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
        begin
            for (int i = 0; i < MAX_SLOTS - 1; i++)
                for (int j = 0; j < MAX_SLOTS - 1 - i; j++)
                    if (coin_set[j] < coin_set[j+1])
                    begin
                        tmp           = coin_set[j];
                        coin_set[j]   = coin_set[j+1];
                        coin_set[j+1] = tmp;
                    end
        end
    endtask

    // Pick an amount: wide random, small, near multiples of a coin value,
    // right at or below a coin value, or an extreme.
    function automatic logic [VAL_W-1:0] pick_amount();
        int unsigned      sel;
        logic [VAL_W-1:0] base;
        sel  = $urandom_range(0, 99);
        base = coin_set[$urandom_range(0, MAX_SLOTS - 1)];
        if (sel < 40)
            return VAL_W'($urandom_range(0, 65535));
        else if (sel < 65)
            return VAL_W'($urandom_range(0, 300));
        else if (sel < 80)
            return VAL_W'(base * $urandom_range(1, 4) + $urandom_range(0, 3));
        else if (sel < 90)
            return VAL_W'(base - $urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return VAL_W'(1);
            2:       return VAL_W'(65534);
            default: return '1;
        endcase
    endfunction

    initial
    begin
        logic [VAL_W-1:0] zero_amounts   [4]  = '{16'd0, 16'd65535, 16'h5555, 16'hAAAA};
        logic [VAL_W-1:0] common_amounts [9]  = '{16'd0, 16'd65535, 16'd1, 16'd2000,
                                                  16'd1999, 16'd3891, 16'd4, 16'd32768,
                                                  16'd32767};
        logic [VAL_W-1:0] wide_amounts   [5]  = '{16'd65535, 16'd65534, 16'd0,
                                                  16'd32768, 16'd12345};
        logic [VAL_W-1:0] rising_amounts [3]  = '{16'd65535, 16'd37, 16'd0};

        // Hold reset, then release it for good.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coin values still at reset: every slot unused, amount passes through.
        foreach (coin_set[k])
            coin_set[k] = '0;
        foreach (zero_amounts[i])
            send_amount(zero_amounts[i]);

        // Common coin set, largest first.
        coin_set = '{16'd2000, 16'd1000, 16'd500, 16'd100, 16'd25, 16'd10, 16'd5, 16'd1};
        program_coins();
        foreach (common_amounts[i])
            send_amount(common_amounts[i]);

        // Full-scale values, ones and unused slots in the middle and at the end.
        coin_set = '{16'd65535, 16'd65535, 16'd32768, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0};
        program_coins();
        foreach (wide_amounts[i])
            send_amount(wide_amounts[i]);

        // Smallest first: slot 0 takes it all, count reaches full scale.
        coin_set = '{16'd1, 16'd2, 16'd5, 16'd10, 16'd25, 16'd100, 16'd500, 16'd65535};
        program_coins();
        foreach (rising_amounts[i])
            send_amount(rising_amounts[i]);

        // Random coin sets, each with its own batch of amounts; the middle
        // phase runs with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            randomize_coins();
            program_coins();
            steady_flow <= (p == RANDOM_PHASES / 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_amount(pick_amount());
        end

        steady_flow <= 1'b0;
        drain_results();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== greedy_coin_change.f =====
src/gcc_pkg.sv
src/gcc_div_stage.sv
src/gcc_out_ser.sv
src/greedy_coin_change.sv
tb/greedy_coin_change_checker.sv
tb/greedy_coin_change_tb.sv
